// ===== design/thermo_scratchpad_decoder_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the scratchpad decoder checker
// Clocked implication checks, reset-qualified, reporting by $error.
// ----------------------------------------------------------------------------
`ifndef THERMO_SCRATCHPAD_DECODER_UNIT_ASSERT_SVH
`define THERMO_SCRATCHPAD_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold at that edge.
`define TSD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("scratchpad decoder check failed: same-cycle implication");

// Next-cycle implication: when ante holds, cons must hold at the following edge.
`define TSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("scratchpad decoder check failed: next-cycle implication");

`endif

// ===== design/tsd_pkg.sv =====
// ----------------------------------------------------------------------------
// tsd_pkg
// Shared constants, types and the CRC-8 step for the scratchpad decoder.
// ----------------------------------------------------------------------------
package tsd_pkg;

	// Dallas CRC-8, reflected polynomial
	localparam logic [7:0] CRC_POLY = 8'h8C;

	// Scratchpad byte positions
	localparam logic [3:0] IDX_TEMP_LSB     = 4'd0;
	localparam logic [3:0] IDX_TEMP_MSB     = 4'd1;
	localparam logic [3:0] IDX_CONFIG       = 4'd4;
	localparam logic [3:0] IDX_COUNT_REMAIN = 4'd6;
	localparam logic [3:0] IDX_COUNT_PER_C  = 4'd7;
	localparam logic [3:0] IDX_CRC          = 4'd8;

	localparam logic [7:0] TEMP_ERROR = 8'hFF;

	// Resolution field, config byte bits 6:5
	localparam logic [1:0] RES_9BIT  = 2'b00;
	localparam logic [1:0] RES_10BIT = 2'b01;
	localparam logic [1:0] RES_11BIT = 2'b10;

	// Bytes captured from one frame, handed to the decoder
	typedef struct packed {
		logic [7:0] temp_low;
		logic [7:0] temp_high;
		logic [7:0] resolution;
		logic [7:0] count_remain;
		logic [7:0] count_per_degree;
	} tsd_frame_t;

	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		logic [7:0] d;
		c = crc;
		d = data;
		for (int i = 0; i < 8; i++) begin
			if (c[0] ^ d[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
			d = d >> 1;
		end
		return c;
	endfunction

endpackage

// ===== design/tsd_if.sv =====
// ----------------------------------------------------------------------------
// tsd_if
// Valid/ready channels of the scratchpad decoder: bytes, results, config.
// ----------------------------------------------------------------------------
interface tsd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] scratch_byte;
	logic       frame_start;

	modport source (output valid, output scratch_byte, output frame_start, input ready);
	modport sink   (input valid, input scratch_byte, input frame_start, output ready);
	modport mon    (input valid, input scratch_byte, input frame_start, input ready);
endinterface

interface tsd_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] temperature_half_degrees;
	logic       crc_error;

	modport source (output valid, output temperature_half_degrees, output crc_error,
		input ready);
	modport sink   (input valid, input temperature_half_degrees, input crc_error,
		output ready);
	modport mon    (input valid, input temperature_half_degrees, input crc_error,
		input ready);
endinterface

interface tsd_cfg_if;
	logic valid;
	logic ready;
	logic sensor_family_s;

	modport source (output valid, output sensor_family_s, input ready);
	modport sink   (input valid, input sensor_family_s, output ready);
	modport mon    (input valid, input sensor_family_s, input ready);
endinterface

// ===== design/tsd_decode.sv =====
// ----------------------------------------------------------------------------
// tsd_decode
// Raw reading to half degrees: family-S extension or resolution mask, /8.
// ----------------------------------------------------------------------------
module tsd_decode (
	input  tsd_pkg::tsd_frame_t frame,
	input  logic                family_s,
	output logic [7:0]          temp_half
);
	import tsd_pkg::*;

	localparam logic [7:0]  CPD_NOMINAL = 8'h10;
	localparam logic [15:0] COUNT_BASE  = 16'd12;
	localparam logic [15:0] FAMS_MASK   = 16'hFFF0;
	localparam logic [15:0] MASK_9BIT   = 16'hFFF8;
	localparam logic [15:0] MASK_10BIT  = 16'hFFFC;
	localparam logic [15:0] MASK_11BIT  = 16'hFFFE;

	logic [15:0] raw;
	logic [15:0] shifted;
	logic [15:0] val;
	logic [15:0] adj;

	assign raw     = {frame.temp_high, frame.temp_low};
	assign shifted = {raw[12:0], 3'b000};

	always_comb begin
		if (family_s) begin
			if (frame.count_per_degree == CPD_NOMINAL) begin
				val = (shifted & FAMS_MASK) + COUNT_BASE - {8'h00, frame.count_remain};
			end else begin
				val = shifted;
			end
		end else begin
			case (frame.resolution[6:5])
				RES_9BIT:  val = raw & MASK_9BIT;
				RES_10BIT: val = raw & MASK_10BIT;
				RES_11BIT: val = raw & MASK_11BIT;
				default:   val = raw;
			endcase
		end
	end

	// Signed divide by 8 toward zero: bias negatives by 7, then shift
	assign adj       = val + (val[15] ? 16'd7 : 16'd0);
	assign temp_half = adj[10:3];

endmodule

// ===== design/thermo_scratchpad_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// thermo_scratchpad_decoder_unit
// Scratchpad byte stream in, CRC-checked temperature in half degrees out.
// ----------------------------------------------------------------------------
// Channel     Dir  Payload                                   Transfer
// byte_in     in   scratch_byte[7:0], frame_start            valid & ready
// result_out  out  temperature_half_degrees[7:0], crc_error  valid & ready
// cfg         in   sensor_family_s                           valid & ready
//
// One byte per cycle is taken unless a stalled result holds the input
// register. A byte sits in the input register, where the CRC step and byte
// capture run; from there the ninth byte of a frame loads the result
// register once it is free, and the result is offered from that register.
// A stalled result holds the input register only when the byte there is a
// frame's last; other bytes keep flowing. Reset clears index, CRC and valids.
// ----------------------------------------------------------------------------
module thermo_scratchpad_decoder_unit (
	input logic           clk,
	input logic           arst_n,
	tsd_byte_if.sink      byte_in,
	tsd_result_if.source  result_out,
	tsd_cfg_if.sink       cfg
);
	import tsd_pkg::*;

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;

	// Frame state
	logic [3:0] idx_q;
	logic [7:0] crc_q;
	tsd_frame_t frame_q;
	logic       family_s_q;

	// Result register
	logic       out_valid_q;
	logic [7:0] temp_q;
	logic       err_q;

	logic [3:0] cur_idx;
	logic [7:0] cur_crc;
	logic       is_last;
	logic       crc_bad;
	logic       out_free;
	logic       s1_go;
	logic       take_in;
	logic [7:0] temp_dec;

	// Frame start restarts index and CRC; an out-of-range index restarts the index
	assign cur_idx = (start_s1 || idx_q > IDX_CRC) ? IDX_TEMP_LSB : idx_q;
	assign cur_crc = start_s1 ? 8'h00 : crc_q;
	assign is_last = (cur_idx == IDX_CRC);
	assign crc_bad = (cur_crc != byte_s1);

	// Advance a non-final byte always; the final byte needs room for its result
	assign out_free = !out_valid_q || result_out.ready;
	assign s1_go    = valid_s1 && (!is_last || out_free);
	assign take_in  = byte_in.valid && byte_in.ready;

	assign byte_in.ready = !valid_s1 || s1_go;
	assign cfg.ready     = 1'b1;

	assign result_out.valid                    = out_valid_q;
	assign result_out.temperature_half_degrees = temp_q;
	assign result_out.crc_error                = err_q;

	tsd_decode u_tsd_decode (
		.frame     (frame_q),
		.family_s  (family_s_q),
		.temp_half (temp_dec)
	);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			idx_q       <= IDX_TEMP_LSB;
			crc_q       <= 8'h00;
			out_valid_q <= 1'b0;
			family_s_q  <= 1'b0;
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end

			// Advance index and CRC; the ninth byte closes the frame
			if (s1_go) begin
				if (is_last) begin
					idx_q <= IDX_TEMP_LSB;
					crc_q <= 8'h00;
				end else begin
					idx_q <= cur_idx + 4'd1;
					crc_q <= crc8_update(cur_crc, byte_s1);
				end
			end

			if (s1_go && is_last) begin
				out_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg.valid) begin
				family_s_q <= cfg.sensor_family_s;
			end
		end
	end

	// Payload: input register, captured bytes, result
	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1  <= byte_in.scratch_byte;
			start_s1 <= byte_in.frame_start;
		end

		if (s1_go) begin
			case (cur_idx)
				IDX_TEMP_LSB:     frame_q.temp_low         <= byte_s1;
				IDX_TEMP_MSB:     frame_q.temp_high        <= byte_s1;
				IDX_CONFIG:       frame_q.resolution       <= byte_s1;
				IDX_COUNT_REMAIN: frame_q.count_remain     <= byte_s1;
				IDX_COUNT_PER_C:  frame_q.count_per_degree <= byte_s1;
				default: ;
			endcase
		end

		// Bytes 0, 1, 4, 6 and 7 are already captured when the CRC byte arrives
		if (s1_go && is_last) begin
			temp_q <= crc_bad ? TEMP_ERROR : temp_dec;
			err_q  <= crc_bad;
		end
	end

endmodule

// ===== design/tsd_checker.sv =====
// ----------------------------------------------------------------------------
// tsd_checker
// Port-level checks on the scratchpad decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "thermo_scratchpad_decoder_unit_assert.svh"

module tsd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_temp,
	input logic       out_err,
	input logic       cfg_valid,
	input logic       cfg_ready
);
	import tsd_pkg::*;

	logic [8:0] out_payload;

	assign out_payload = {out_temp, out_err};

	// A CRC failure always reports the error code
	`TSD_ASSERT_IMPLY(a_err_code, clk, arst_n, out_valid && out_err, out_temp == TEMP_ERROR)

	// With no result pending, the byte side never stalls
	`TSD_ASSERT_IMPLY(a_ready_when_empty, clk, arst_n, !out_valid, in_ready)

	// Config writes are always taken
	`TSD_ASSERT_IMPLY(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready)

	// A stalled result holds
	`TSD_ASSERT_NEXT(a_result_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_payload))

endmodule

bind thermo_scratchpad_decoder_unit tsd_checker u_tsd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (byte_in.ready),
	.out_valid (result_out.valid),
	.out_ready (result_out.ready),
	.out_temp  (result_out.temperature_half_degrees),
	.out_err   (result_out.crc_error),
	.cfg_valid (cfg.valid),
	.cfg_ready (cfg.ready)
);

// ===== test/tb_thermo_scratchpad_decoder_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_thermo_scratchpad_decoder_unit
// Feeds scratchpad frames (good, corrupted, cut short, unaligned noise) into
// the decoder under both sensor decodings. Every result is checked against a
// local frame tracker, and both channels stall at random.
// ----------------------------------------------------------------------------
module tb_thermo_scratchpad_decoder_unit;
	import tsd_pkg::*;

	localparam int CLK_PERIOD    = 12;
	localparam int RESET_CYCLES  = 10;
	localparam int IDLE_PCT      = 12;
	localparam int SETTLE_CYCLES = 4;    // byte register plus result register, with margin
	localparam int TAIL_CYCLES   = 20;
	localparam int HOLD_CYCLES   = 80;   // long receiver hold-off, fills the pipeline
	localparam int PHASES        = 6;
	localparam int PHASE_BYTES   = 134;  // about 800 random bytes in total

	localparam logic [7:0] COUNT_PER_C_NATIVE = 8'h10;

	typedef struct packed {
		logic [7:0] half_deg;
		logic       crc_bad;
	} reading_t;

	typedef logic [8:0][7:0] frame_bytes_t;

	// How a directed row's result is obtained
	typedef enum logic [1:0] {EXP_NONE, EXP_TYPED, EXP_PREDICTED} exp_kind_t;

	typedef struct packed {
		logic        start;
		logic [3:0]  nbytes;
		logic [15:0] raw;
		logic [7:0]  resolution;
		logic [7:0]  count_remain;
		logic [7:0]  count_per_c;
		logic        bad_crc;
		exp_kind_t   kind;
		reading_t    typed;
	} dir_row_t;

	logic clk;
	logic arst_n;

	tsd_byte_if   byte_ch ();
	tsd_result_if res_ch ();
	tsd_cfg_if    cfg_ch ();

	thermo_scratchpad_decoder_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_in    (byte_ch),
		.result_out (res_ch),
		.cfg        (cfg_ch)
	);

	// Tracker state: our own copy of what the block holds
	logic [3:0] sp_index;
	logic [7:0] sp_crc;
	tsd_frame_t sp_frame;
	logic       sp_family_s;

	reading_t pending_readings[$];
	int       errors;
	bit       quiet;      // no idling on either side while set
	bit       hold_req;   // ask the receiver for one long hold-off

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	// One byte step of the reflected Dallas CRC-8, computed bit-serially LSB first
	function automatic logic [7:0] dallas_crc_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		logic       fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c  = {1'b0, c[7:1]} ^ (fb ? CRC_POLY : 8'h00);
		end
		return c;
	endfunction

	// Raw reading to half degrees: family-S extension or resolution mask,
	// then a signed divide by 8 that truncates toward zero
	function automatic logic [7:0] decode_half_degrees(input tsd_frame_t f, input logic fam_s);
		logic [15:0]        raw;
		logic signed [15:0] q;
		raw = {f.temp_high, f.temp_low};
		if (fam_s) begin
			raw = raw << 3;
			if (f.count_per_degree == COUNT_PER_C_NATIVE)
				raw = (raw & 16'hFFF0) + 16'd12 - {8'h00, f.count_remain};
		end else begin
			case (f.resolution[6:5])
				RES_9BIT:  raw[2:0] = 3'b000;
				RES_10BIT: raw[1:0] = 2'b00;
				RES_11BIT: raw[0]   = 1'b0;
				default: ;
			endcase
		end
		q = $signed(raw) / 16'sd8;
		return q[7:0];
	endfunction

	// Advance the tracker by one accepted byte; the ninth byte of a frame
	// queues the reading that the block must return
	task automatic scratchpad_step(input logic [7:0] b, input logic fs,
			input bit use_typed, input reading_t typed);
		reading_t r;
		if (fs) begin
			sp_index = '0;
			sp_crc   = '0;
		end
		case (sp_index)
			IDX_TEMP_LSB:     sp_frame.temp_low         = b;
			IDX_TEMP_MSB:     sp_frame.temp_high        = b;
			IDX_CONFIG:       sp_frame.resolution       = b;
			IDX_COUNT_REMAIN: sp_frame.count_remain     = b;
			IDX_COUNT_PER_C:  sp_frame.count_per_degree = b;
			default: ;
		endcase
		if (sp_index == IDX_CRC) begin
			if (use_typed) begin
				r = typed;
			end else if (sp_crc != b) begin
				r.half_deg = TEMP_ERROR;
				r.crc_bad  = 1'b1;
			end else begin
				r.half_deg = decode_half_degrees(sp_frame, sp_family_s);
				r.crc_bad  = 1'b0;
			end
			pending_readings.push_back(r);
			sp_index = '0;
			sp_crc   = '0;
		end else begin
			sp_crc   = dallas_crc_step(sp_crc, b);
			sp_index = sp_index + 4'd1;
		end
	endtask

	// Offer one byte from the falling edge on, with random gaps ahead of it;
	// valid stays high after the transfer so back-to-back bytes flow
	task automatic send_byte(input logic [7:0] b, input logic fs,
			input bit use_typed, input reading_t typed);
		@(negedge clk);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			byte_ch.valid = 1'b0;
			@(negedge clk);
		end
		byte_ch.valid        = 1'b1;
		byte_ch.scratch_byte = b;
		byte_ch.frame_start  = fs;
		do @(posedge clk); while (!byte_ch.ready);
		scratchpad_step(b, fs, use_typed, typed);
	endtask

	task automatic park_sender();
		@(negedge clk);
		byte_ch.valid = 1'b0;
	endtask

	// Build a scratchpad image; filler bytes are random, the CRC byte is
	// either correct or has one bit flipped
	function automatic frame_bytes_t build_frame(input logic [15:0] raw,
			input logic [7:0] res, input logic [7:0] cr, input logic [7:0] cpc,
			input logic bad);
		frame_bytes_t fb;
		logic [7:0]   crc;
		fb[IDX_TEMP_LSB]     = raw[7:0];
		fb[IDX_TEMP_MSB]     = raw[15:8];
		fb[2]                = 8'($urandom);
		fb[3]                = 8'($urandom);
		fb[IDX_CONFIG]       = res;
		fb[5]                = 8'($urandom);
		fb[IDX_COUNT_REMAIN] = cr;
		fb[IDX_COUNT_PER_C]  = cpc;
		crc = 8'h00;
		for (int i = 0; i < 8; i++)
			crc = dallas_crc_step(crc, fb[i]);
		fb[IDX_CRC] = bad ? (crc ^ 8'(1 << $urandom_range(7))) : crc;
		return fb;
	endfunction

	task automatic send_frame(input frame_bytes_t fb, input int n, input logic start,
			input bit use_typed, input reading_t typed, inout int sent);
		for (int i = 0; i < n; i++) begin
			send_byte(fb[i], (i == 0) ? start : 1'b0, use_typed && (i == 8), typed);
			sent++;
		end
	endtask

	// Pause the sender until every reading is back and the byte register
	// has had time to empty
	task automatic drain_readings();
		park_sender();
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_family(input logic fam_s);
		@(negedge clk);
		cfg_ch.valid           = 1'b1;
		cfg_ch.sensor_family_s = fam_s;
		do @(posedge clk); while (!cfg_ch.ready);
		sp_family_s = fam_s;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Result side: stall at random, or hold off for a long count on request,
	// and compare each transfer with the oldest queued reading
	initial begin : result_sink
		int       hold_left;
		reading_t want;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				res_ch.ready = 1'b0;
				hold_left--;
			end else begin
				res_ch.ready = !(!quiet && $urandom_range(99) < IDLE_PCT);
			end
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				if (pending_readings.size() == 0) begin
					errors++;
					$display("%0t: unexpected reading: expected none, actual %0d err %0d",
						$time, res_ch.temperature_half_degrees, res_ch.crc_error);
				end else begin
					want = pending_readings.pop_front();
					if (res_ch.temperature_half_degrees !== want.half_deg) begin
						errors++;
						$display("%0t: temperature_half_degrees: expected %0d, actual %0d",
							$time, want.half_deg, res_ch.temperature_half_degrees);
					end
					if (res_ch.crc_error !== want.crc_bad) begin
						errors++;
						$display("%0t: crc_error: expected %0d, actual %0d",
							$time, want.crc_bad, res_ch.crc_error);
					end
				end
			end
		end
	end

	// Main stimulus
	initial begin : stimulus
		dir_row_t     dir_rows[4];
		frame_bytes_t fb;
		reading_t     no_reading;
		logic [15:0]  raw;
		logic [7:0]   hi;
		logic [7:0]   cr;
		logic [7:0]   cpc;
		logic         start;
		int           sent;
		int           pick;

		// Drive every input to a known value and hold reset
		arst_n                 = 1'b0;
		byte_ch.valid          = 1'b0;
		byte_ch.scratch_byte   = 8'h00;
		byte_ch.frame_start    = 1'b0;
		res_ch.ready           = 1'b0;
		cfg_ch.valid           = 1'b0;
		cfg_ch.sensor_family_s = 1'b0;
		sp_index    = '0;
		sp_crc      = '0;
		sp_frame    = '0;
		sp_family_s = 1'b0;
		errors      = 0;
		quiet       = 1'b0;
		hold_req    = 1'b0;
		no_reading  = '0;
		sent        = 0;

		// Directed frames under the reset decoding:
		//   zero reading, full resolution, good CRC
		//   a frame cut after four bytes, dropped by the next frame start
		//   largest positive raw in 9-bit mode with a corrupted CRC
		//   most negative raw, sent right after a frame end without a start mark
		dir_rows[0] = '{1'b1, 4'd9, 16'h0000, 8'h7F, 8'h0C, 8'h10, 1'b0,
			EXP_TYPED, reading_t'({8'h00, 1'b0})};
		dir_rows[1] = '{1'b1, 4'd4, 16'h0550, 8'h7F, 8'h00, 8'h10, 1'b0,
			EXP_NONE, reading_t'('0)};
		dir_rows[2] = '{1'b1, 4'd9, 16'h7FFF, 8'h1F, 8'hFF, 8'hFF, 1'b1,
			EXP_TYPED, reading_t'({TEMP_ERROR, 1'b1})};
		dir_rows[3] = '{1'b0, 4'd9, 16'h8000, 8'h60, 8'h00, 8'h00, 1'b0,
			EXP_PREDICTED, reading_t'('0)};

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) begin
			fb = build_frame(dir_rows[i].raw, dir_rows[i].resolution,
				dir_rows[i].count_remain, dir_rows[i].count_per_c, dir_rows[i].bad_crc);
			send_frame(fb, dir_rows[i].nbytes, dir_rows[i].start,
				dir_rows[i].kind == EXP_TYPED, dir_rows[i].typed, sent);
		end

		// Random phases, alternating the decoding so both settings are used
		// and the register is written more than once
		for (int p = 0; p < PHASES; p++) begin
			drain_readings();
			write_family((p % 2) == 0);
			quiet = (p == 3);
			// Long receiver hold-off while the sender keeps offering frames
			if (p == 1 || p == 4)
				hold_req = 1'b1;
			sent = 0;
			while (sent < PHASE_BYTES) begin
				pick = $urandom_range(99);
				case ($urandom_range(4))
					0:       hi = 8'h00;
					1:       hi = 8'hFF;
					2:       hi = 8'h7F;
					3:       hi = 8'h80;
					default: hi = 8'($urandom);
				endcase
				raw = {hi, 8'($urandom)};
				cr  = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(16));
				cpc = ($urandom_range(9) < 7) ? COUNT_PER_C_NATIVE : 8'($urandom);
				if (pick < 85) begin
					// Whole frame, mostly with a good CRC; a start mark is
					// optional when the block is already at a frame boundary
					start = (sp_index != 4'd0) ? 1'b1 : 1'($urandom_range(1));
					fb = build_frame(raw, 8'($urandom), cr, cpc, pick >= 70);
					send_frame(fb, 9, start, 1'b0, no_reading, sent);
				end else if (pick < 93) begin
					// Frame cut short; the next start mark drops it
					fb = build_frame(raw, 8'($urandom), cr, cpc, 1'b0);
					send_frame(fb, $urandom_range(1, 8), 1'b1, 1'b0, no_reading, sent);
				end else begin
					// Loose bytes with random start marks
					repeat ($urandom_range(1, 5)) begin
						send_byte(8'($urandom), 1'($urandom_range(1)), 1'b0, no_reading);
						sent++;
					end
				end
			end
			quiet = 1'b0;
		end

		// Wait out the last readings, then watch for stray ones
		drain_readings();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (errors == 0 && pending_readings.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
